// File: src/prrs_pkg.sv
package prrs_pkg;

    // Field widths fixed by the request and result formats
    localparam int TIME_W       = 16;
    localparam int ID_W         = 5;
    localparam int DEF_MAX_JOBS = 16;

    // Request action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Side-band control that travels with each entry through the divider
    typedef struct packed {
        logic elig;   // entry has arrived and still has work
        logic last;   // last entry of the scan
    } t_div_ctl;

endpackage

// File: src/prrs_ifs.sv
interface prrs_req_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [prrs_pkg::TIME_W-1:0] arrival_time;
    logic [prrs_pkg::TIME_W-1:0] run_time;

    modport source (output valid, action, arrival_time, run_time, input ready);
    modport sink   (input valid, action, arrival_time, run_time, output ready);
endinterface

interface prrs_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [prrs_pkg::ID_W-1:0]   job_id;
    logic                        idle;
    logic                        job_done;
    logic                        all_done;
    logic [prrs_pkg::TIME_W-1:0] tick_time;

    modport source (output valid, job_id, idle, job_done, all_done, tick_time, input ready);
    modport sink   (input valid, job_id, idle, job_done, all_done, tick_time, output ready);
endinterface

// File: src/preemptive_response_ratio_scheduler.sv
// Load request: appends an entry to the job table while it is not full; no result.
// Tick request: one table entry is read per cycle into a 16-stage pipelined divider, and
// the result is built once the last entry leaves it (with no jobs, the scan is skipped).
// One request is in work at a time; a new request is taken while a result waits.
// Synchronous active-low reset clears the job count, time and control; the job
// table is not cleared and only entries below the job count are read.
module preemptive_response_ratio_scheduler #(
    parameter int MAX_JOBS = prrs_pkg::DEF_MAX_JOBS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    prrs_req_if.sink    i_req,
    prrs_rsp_if.source  o_rsp
);
    import prrs_pkg::*;

    localparam int IDX_W = $clog2(MAX_JOBS);
    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam int TAG_W = IDX_W + TIME_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_scan_idx;
    logic [TIME_W-1:0]   r_now;

    // Job table: {arrival, remaining} per entry
    logic [2*TIME_W-1:0] r_mem [MAX_JOBS];
    logic [2*TIME_W-1:0] r_rd_data;
    logic                r_rd_vld;
    logic                r_rd_last;
    logic [IDX_W-1:0]    r_rd_idx;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [2*TIME_W-1:0] mem_wdata;

    // Best-candidate tracking
    logic                r_found;
    logic [1:0]          r_nz;
    logic [IDX_W-1:0]    r_best_idx;
    logic [TIME_W-1:0]   r_best_q;
    logic [TIME_W-1:0]   r_best_a;
    logic [TIME_W-1:0]   r_best_r;

    // Output register
    logic                r_out_vld;
    logic [ID_W-1:0]     r_out_id;
    logic                r_out_idle;
    logic                r_out_done;
    logic                r_out_all;
    logic [TIME_W-1:0]   r_out_time;

    logic                req_acc;
    logic                load_acc;
    logic                tick_acc;
    logic                fin_go;
    logic                scan_last;
    logic [CNT_W-1:0]    id_full;

    logic [TIME_W-1:0]   rd_arr;
    logic [TIME_W-1:0]   rd_rem;
    t_div_ctl            div_in_ctl;

    logic                d_vld;
    logic [TIME_W-1:0]   d_quo;
    logic [TIME_W-1:0]   d_dvs;
    logic [TAG_W-1:0]    d_tag;
    t_div_ctl            d_ctl;
    logic [IDX_W-1:0]    d_idx;
    logic [TIME_W-1:0]   d_arr;
    logic                d_better;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign load_acc    = req_acc && (i_req.action == ACT_LOAD);
    assign tick_acc    = req_acc && (i_req.action == ACT_TICK);
    assign fin_go      = (r_state == S_FIN) && (!r_out_vld || o_rsp.ready);
    assign scan_last   = (r_scan_idx == CNT_W'(r_count - 1'b1));

    // Sequence the scan
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (tick_acc) begin
                    n_state = (r_count == '0) ? S_FIN : S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (d_vld && d_ctl.last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (fin_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_now      <= '0;
            r_scan_idx <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_SCAN);
            if (load_acc && (r_count < CNT_W'(MAX_JOBS))) begin
                r_count <= r_count + 1'b1;
            end
            if (tick_acc) begin
                r_scan_idx <= '0;
            end else if (r_state == S_SCAN) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
            if (fin_go) begin
                r_now <= r_now + 1'b1;
            end
        end
    end

    // Write port: append on load, write back the decremented entry on finish
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_count[IDX_W-1:0];
        mem_wdata = {i_req.arrival_time, i_req.run_time};
        if (load_acc && (r_count < CNT_W'(MAX_JOBS))) begin
            mem_we = 1'b1;
        end else if (fin_go && r_found) begin
            mem_we    = 1'b1;
            mem_waddr = r_best_idx;
            mem_wdata = {r_best_a, r_best_r - 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[r_scan_idx[IDX_W-1:0]];
        r_rd_idx  <= r_scan_idx[IDX_W-1:0];
        r_rd_last <= scan_last;
    end

    // Feed each entry into the divider: (now - arrival) / remaining
    assign rd_arr          = r_rd_data[2*TIME_W-1:TIME_W];
    assign rd_rem          = r_rd_data[TIME_W-1:0];
    assign div_in_ctl.elig = (rd_rem != '0) && (rd_arr <= r_now);
    assign div_in_ctl.last = r_rd_last;

    prrs_div_pipe #(
        .TAG_W (TAG_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_rd_vld),
        .i_dividend (r_now - rd_arr),
        .i_divisor  (rd_rem),
        .i_tag      ({r_rd_idx, rd_arr}),
        .i_ctl      (div_in_ctl),
        .o_valid    (d_vld),
        .o_quot     (d_quo),
        .o_divisor  (d_dvs),
        .o_tag      (d_tag),
        .o_ctl      (d_ctl)
    );

    assign d_idx = d_tag[TAG_W-1:TIME_W];
    assign d_arr = d_tag[TIME_W-1:0];

    // Higher quotient wins; equal quotient goes to the earlier arrival, then lower id
    assign d_better = d_vld && d_ctl.elig &&
                      (!r_found || (d_quo > r_best_q) ||
                       ((d_quo == r_best_q) && (d_arr < r_best_a)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_nz    <= '0;
        end else if (tick_acc) begin
            r_found <= 1'b0;
            r_nz    <= '0;
        end else if (d_vld) begin
            if (d_better) begin
                r_found <= 1'b1;
            end
            if ((d_dvs != '0) && (r_nz != 2'd2)) begin
                r_nz <= r_nz + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_better) begin
            r_best_idx <= d_idx;
            r_best_q   <= d_quo;
            r_best_a   <= d_arr;
            r_best_r   <= d_dvs;
        end
    end

    // Build the result; all done when no work is left after this decrement
    assign id_full = CNT_W'(r_best_idx) + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fin_go) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_out_id   <= r_found ? ID_W'(id_full) : '0;
            r_out_idle <= !r_found;
            r_out_done <= r_found && (r_best_r == TIME_W'(1));
            r_out_all  <= (r_nz == 2'd0) ||
                          ((r_nz == 2'd1) && r_found && (r_best_r == TIME_W'(1)));
            r_out_time <= r_now;
        end
    end

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.job_id    = r_out_id;
    assign o_rsp.idle      = r_out_idle;
    assign o_rsp.job_done  = r_out_done;
    assign o_rsp.all_done  = r_out_all;
    assign o_rsp.tick_time = r_out_time;

    // An idle result names no job and reports no completion
    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.idle) |-> ((o_rsp.job_id == '0) && !o_rsp.job_done))
        else $error("idle result carries a job");

    // Divider traffic only exists while a scan is in work
    a_div_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_vld |-> ((r_state == S_SCAN) || (r_state == S_DRAIN)))
        else $error("divider output outside a scan");

    // A chosen job implies at least one entry with work was seen
    a_found_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && r_found) |-> (r_nz != 2'd0))
        else $error("job chosen without pending work");

    // Time advances by exactly one on each finished tick
    a_time_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_go |=> (r_now == $past(r_now) + 1'b1))
        else $error("time did not advance");

endmodule

// File: src/prrs_div_pipe.sv
module prrs_div_pipe #(
    parameter int TAG_W = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [prrs_pkg::TIME_W-1:0] i_dividend,
    input  logic [prrs_pkg::TIME_W-1:0] i_divisor,
    input  logic [TAG_W-1:0]            i_tag,
    input  prrs_pkg::t_div_ctl          i_ctl,
    output logic                        o_valid,
    output logic [prrs_pkg::TIME_W-1:0] o_quot,
    output logic [prrs_pkg::TIME_W-1:0] o_divisor,
    output logic [TAG_W-1:0]            o_tag,
    output prrs_pkg::t_div_ctl          o_ctl
);
    import prrs_pkg::*;

    localparam int N = TIME_W;

    // Stage 0 is the input; stages 1..N are registers, one quotient bit each
    logic              s_vld [N+1];
    logic [TIME_W-1:0] s_rem [N+1];
    logic [TIME_W-1:0] s_quo [N+1];
    logic [TIME_W-1:0] s_dvs [N+1];
    logic [TAG_W-1:0]  s_tag [N+1];
    t_div_ctl          s_ctl [N+1];

    assign s_vld[0] = i_valid;
    assign s_rem[0] = '0;
    assign s_quo[0] = i_dividend;
    assign s_dvs[0] = i_divisor;
    assign s_tag[0] = i_tag;
    assign s_ctl[0] = i_ctl;

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [TIME_W:0] trial;
        logic [TIME_W:0] diff;
        logic            ge;

        // Shift in the next dividend bit and try one subtract
        always_comb begin
            trial = {s_rem[k], s_quo[k][TIME_W-1]};
            diff  = trial - {1'b0, s_dvs[k]};
            ge    = (trial >= {1'b0, s_dvs[k]});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                s_vld[k+1] <= 1'b0;
            end else begin
                s_vld[k+1] <= s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            s_rem[k+1] <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
            s_quo[k+1] <= {s_quo[k][TIME_W-2:0], ge};
            s_dvs[k+1] <= s_dvs[k];
            s_tag[k+1] <= s_tag[k];
            s_ctl[k+1] <= s_ctl[k];
        end
    end

    assign o_valid   = s_vld[N];
    assign o_quot    = s_quo[N];
    assign o_divisor = s_dvs[N];
    assign o_tag     = s_tag[N];
    assign o_ctl     = s_ctl[N];

endmodule
